@@ src/kwl_pkg.sv @@
// Shared types, constants and keyword tables for the keyword/number lexer.
`timescale 1ns / 1ps

package kwl_pkg;

    // Keyword table: ten keywords, longest is 17 characters.
    localparam int NKW       = 10;
    localparam int KW_COLS   = 17;
    localparam int KW_BITS   = KW_COLS * 8;
    localparam int CIDX_W    = 5;

    // Result item field widths.
    localparam int KIND_W    = 4;
    localparam int FIELD_W   = 16;

    // Token kinds beyond the keyword codes 0 to 9.
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd11;
    localparam logic [KIND_W-1:0] KIND_END    = 4'd12;

    // Depth of the token queue between front and back.
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = QPTR_W + 1;

    // Keyword text, first character in the most significant used byte.
    localparam logic [KW_BITS-1:0] KW_TEXT [NKW] = '{
        KW_BITS'({"Struct", "_define"}),
        KW_BITS'({"Max_gate", "_prospect"}),
        KW_BITS'({"Max", "_equip"}),
        KW_BITS'({"Max", "_able"}),
        KW_BITS'({"Open", "_define"}),
        KW_BITS'({"Closed", "_define"}),
        KW_BITS'({"New", "_define"}),
        KW_BITS'("New_val"),
        KW_BITS'({"Commit", "_table"}),
        KW_BITS'({"Sequence", "_count"})
    };

    localparam logic [CIDX_W-1:0] KW_LEN [NKW] = '{
        5'd13, 5'd17, 5'd9, 5'd8, 5'd11, 5'd13, 5'd10, 5'd7, 5'd12, 5'd14
    };

    // Scan state of the front end.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_NUM  = 3'b100
    } scan_mode_t;

    // One input item.
    typedef struct packed {
        logic       is_end;
        logic [7:0] char_byte;
    } char_item_t;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [FIELD_W-1:0] token_start;
        logic [FIELD_W-1:0] token_length;
        logic               last_of_run;
    } token_item_t;

    // One token without the run marker.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } tok_t;

    // All results of one input item: one token, or two when pair is set.
    typedef struct packed {
        logic pair;
        tok_t first;
        tok_t second;
    } bundle_t;

    // Keywords whose character at position idx equals b.
    function automatic logic [NKW-1:0] match_mask(logic [CIDX_W-1:0] idx,
                                                  logic [7:0] b);
        logic [NKW-1:0] m;
        int             sh;
        m = '0;
        for (int k = 0; k < NKW; k++)
        begin
            if (idx < KW_LEN[k])
            begin
                sh = (int'(KW_LEN[k]) - 1 - int'(idx)) * 8;
                if (KW_TEXT[k][sh +: 8] == b)
                begin
                    m[k] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

@@ src/kwl_front.sv @@
// Front end: accepts bytes, tracks the open token and builds result bundles.
`timescale 1ns / 1ps

module kwl_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kwl_pkg::char_item_t char_item,
    input  logic                full,
    output logic                bundle_push,
    output kwl_pkg::bundle_t    bundle
);
    import kwl_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    scan_mode_t            mode_reg,  mode_next;
    logic [NKW-1:0]        alive_reg, alive_next;
    logic [CIDX_W-1:0]     cidx_reg,  cidx_next;
    logic [POS_WIDTH-1:0]  start_reg, start_next;
    logic [POS_WIDTH-1:0]  pos_reg,   pos_next;

    logic                  accept;
    logic                  is_letter;
    logic                  is_digit;
    logic                  is_word_ch;
    logic                  has_open;
    logic [POS_WIDTH-1:0]  len_raw;
    logic [POS_WIDTH+FIELD_W-1:0] pos_ext;
    logic [POS_WIDTH+FIELD_W-1:0] start_ext;
    logic [POS_WIDTH+FIELD_W-1:0] len_ext;
    logic [KIND_W-1:0]     word_kind;
    tok_t                  close_tok;
    tok_t                  end_tok;

    assign accept = push && !full;

    // Character classes.
    always_comb
    begin
        is_letter  = (char_item.char_byte >= 8'h41 && char_item.char_byte <= 8'h5A) ||
                     (char_item.char_byte >= 8'h61 && char_item.char_byte <= 8'h7A);
        is_digit   = char_item.char_byte >= 8'h30 && char_item.char_byte <= 8'h39;
        is_word_ch = is_letter || is_digit || (char_item.char_byte == 8'h5F);
    end

    // Keyword resolution: the lowest live keyword of exactly this length wins.
    always_comb
    begin
        word_kind = KIND_IDENT;
        for (int k = NKW - 1; k >= 0; k--)
        begin
            if (alive_reg[k] && cidx_reg == KW_LEN[k])
            begin
                word_kind = KIND_W'(k);
            end
        end
    end

    // Token that closes now, with fields cut or widened to the port width.
    always_comb
    begin
        len_raw   = (pos_reg >= start_reg) ? (pos_reg - start_reg) : '0;
        pos_ext   = {{FIELD_W{1'b0}}, pos_reg};
        start_ext = {{FIELD_W{1'b0}}, start_reg};
        len_ext   = {{FIELD_W{1'b0}}, len_raw};
        unique case (mode_reg)
            MODE_WORD:
            begin
                has_open       = 1'b1;
                close_tok.kind = word_kind;
            end
            MODE_NUM:
            begin
                has_open       = 1'b1;
                close_tok.kind = KIND_NUMBER;
            end
            default:
            begin
                has_open       = 1'b0;
                close_tok.kind = KIND_IDENT;
            end
        endcase
        close_tok.start  = start_ext[FIELD_W-1:0];
        close_tok.length = len_ext[FIELD_W-1:0];
        end_tok.kind     = KIND_END;
        end_tok.start    = pos_ext[FIELD_W-1:0];
        end_tok.length   = '0;
    end

    // Next state and the bundle for the queue.
    always_comb
    begin
        mode_next   = mode_reg;
        alive_next  = alive_reg;
        cidx_next   = cidx_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        bundle_push = 1'b0;
        bundle      = '{pair: 1'b0, first: close_tok, second: end_tok};
        if (accept)
        begin
            if (char_item.is_end)
            begin
                // End marker: close the open token, report END, start over.
                bundle_push = 1'b1;
                bundle.pair = has_open;
                if (!has_open)
                begin
                    bundle.first = end_tok;
                end
                mode_next  = MODE_IDLE;
                alive_next = '0;
                cidx_next  = '0;
                start_next = '0;
                pos_next   = '0;
            end
            else
            begin
                if (mode_reg == MODE_WORD && is_word_ch)
                begin
                    alive_next = alive_reg & match_mask(cidx_reg, char_item.char_byte);
                    if (cidx_reg != '1)
                    begin
                        cidx_next = cidx_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_NUM && is_digit)
                begin
                    mode_next = MODE_NUM;
                end
                else
                begin
                    bundle_push = has_open;
                    mode_next   = MODE_IDLE;
                    if (is_letter)
                    begin
                        mode_next  = MODE_WORD;
                        start_next = pos_reg;
                        alive_next = match_mask('0, char_item.char_byte);
                        cidx_next  = CIDX_W'(1);
                    end
                    else if (is_digit)
                    begin
                        mode_next  = MODE_NUM;
                        start_next = pos_reg;
                    end
                end
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            alive_reg <= '0;
            cidx_reg  <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            alive_reg <= alive_next;
            cidx_reg  <= cidx_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

@@ src/kwl_back.sv @@
// Back end: queue of result bundles and the serializer that hands out tokens.
`timescale 1ns / 1ps

module kwl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 bundle_push,
    input  kwl_pkg::bundle_t     bundle,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output kwl_pkg::token_item_t token
);
    import kwl_pkg::*;

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                sel_reg,    sel_next;

    bundle_t             head;
    logic                wr_en;
    logic                take;
    logic                deq;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];
    assign wr_en = bundle_push && !full;
    assign take  = pop && !empty;
    // A bundle leaves once its last token has been taken.
    assign deq   = take && (!head.pair || sel_reg);

    // Present the first token of a pair, then the second one.
    always_comb
    begin
        if (head.pair && !sel_reg)
        begin
            token.token_kind   = head.first.kind;
            token.token_start  = head.first.start;
            token.token_length = head.first.length;
            token.last_of_run  = 1'b0;
        end
        else if (head.pair)
        begin
            token.token_kind   = head.second.kind;
            token.token_start  = head.second.start;
            token.token_length = head.second.length;
            token.last_of_run  = 1'b1;
        end
        else
        begin
            token.token_kind   = head.first.kind;
            token.token_start  = head.first.start;
            token.token_length = head.first.length;
            token.last_of_run  = 1'b1;
        end
    end

    // Pointer, count and pair-select updates.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(deq);
        sel_next    = sel_reg;
        if (take)
        begin
            sel_next = !deq;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= bundle;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

endmodule

@@ src/keyword_number_lexer.sv @@
// A token closed by an accepted byte is written into the token queue and shown from there.
// Throughput: one byte per cycle; the front stalls only when the four-entry queue is full.
// Output: one token per cycle if not empty; an end marker closing a token yields two.
// Reset clears scan state, position counter and the token queue; an end marker also
// returns the scanner to its reset state, so the next source starts at position zero.
`timescale 1ns / 1ps

module keyword_number_lexer #(
    parameter int POS_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  kwl_pkg::char_item_t  char_item,
    output logic                 empty,
    input  logic                 pop,
    output kwl_pkg::token_item_t token
);
    import kwl_pkg::*;

    logic    bundle_push;
    bundle_t bundle;

    // Byte classification and token tracking.
    kwl_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .char_item   (char_item),
        .full        (full),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    // Token queue and output serializer.
    kwl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle_push (bundle_push),
        .bundle      (bundle),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .token       (token)
    );

    // An end marker always produces a token.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && char_item.is_end |=> !empty)
        else $error("end marker produced no token");

    // The second token of a pair is still waiting after the first is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !token.last_of_run |=> !empty)
        else $error("second token of a pair was lost");

    // Token kinds stay in the defined range.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> token.token_kind <= KIND_END)
        else $error("token kind out of range");

    // An END token closes its run and carries no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && token.token_kind == KIND_END |->
            token.last_of_run && token.token_length == '0)
        else $error("malformed end token");

endmodule
